[src/ilp_pkg.sv]
package ilp_pkg;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_SEP     = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
  localparam logic [CHAR_W-1:0] CH_UPPER_B = 8'h42;
  localparam logic [CHAR_W-1:0] CH_LOWER_O = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_UPPER_O = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;

  localparam logic [4:0] NOT_A_DIGIT = 5'd16;

  function automatic logic [4:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [4:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h41 + 8'd10);
    end else begin
      d = NOT_A_DIGIT;
    end
    return d;
  endfunction

  function automatic logic [4:0] radix_base(input radix_t r);
    logic [4:0] b;
    unique case (r)
      RADIX_BIN: b = 5'd2;
      RADIX_OCT: b = 5'd8;
      RADIX_HEX: b = 5'd16;
      default:   b = 5'd10;
    endcase
    return b;
  endfunction

endpackage

[src/integer_literal_parser_unit.sv]
// Integer literal parser.
// The input stream carries one ASCII character of a literal per word on
// s_tdata, with s_tlast high on the last character of the literal. A leading
// 0b, 0o or 0x (either case) selects base 2, 8 or 16, else the base is 10.
// Underscores are allowed only between two digits of the base.
// For every literal the output stream gives exactly one word, on the cycle
// after the last character is accepted: m_tuser carries the ok flag and
// m_tdata the value, which is zero when ok is low. Characters that are not
// last give no output word.
// The block takes one character per cycle unless the receiver stalls. Each
// character is folded into the parse state by one shift-and-add of the
// accumulator, which sets the rate.
// While the receiver stalls, the result word is held in the output register
// and s_tready is low, so every character waits until that register is free
// or is being emptied in the same cycle.
// Reset clears the parse state and the output valid; the block is ready in
// the first cycle after reset.
module integer_literal_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // character[7:0]
  input  logic        s_tlast,   // final_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // number[30:0], zero[31]
  output logic [0:0]  m_tuser    // ok[0]
);

  localparam int unsigned VW = ilp_pkg::VALUE_W;

  logic [1:0]    char_position, char_position_next;
  ilp_pkg::radix_t radix_code, radix_code_next;
  logic [VW-1:0] accumulator, accumulator_next;
  logic          overflowed, overflowed_next;
  logic          after_digit, after_digit_next;
  logic          malformed, malformed_next;
  logic          first_was_zero, first_was_zero_next;

  logic          s_fire;
  logic          took_prefix;
  ilp_pkg::radix_t prefix_code;
  logic [4:0]    digit;
  logic [VW+3:0] product;
  logic [VW+3:0] sum;
  logic          good;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  always_comb begin
    unique case (s_tdata)
      ilp_pkg::CH_LOWER_B, ilp_pkg::CH_UPPER_B: prefix_code = ilp_pkg::RADIX_BIN;
      ilp_pkg::CH_LOWER_O, ilp_pkg::CH_UPPER_O: prefix_code = ilp_pkg::RADIX_OCT;
      ilp_pkg::CH_LOWER_X, ilp_pkg::CH_UPPER_X: prefix_code = ilp_pkg::RADIX_HEX;
      default:                                  prefix_code = ilp_pkg::RADIX_DEC;
    endcase
    took_prefix = (char_position == 2'd1) && first_was_zero && !malformed &&
                  (prefix_code != ilp_pkg::RADIX_DEC);

    digit = ilp_pkg::digit_value(s_tdata);
    unique case (radix_code)
      ilp_pkg::RADIX_BIN: product = {3'b000, accumulator, 1'b0};
      ilp_pkg::RADIX_OCT: product = {1'b0, accumulator, 3'b000};
      ilp_pkg::RADIX_HEX: product = {accumulator, 4'b0000};
      default:            product = {1'b0, accumulator, 3'b000} +
                                    {3'b000, accumulator, 1'b0};
    endcase
    sum = product + {{(VW-1){1'b0}}, digit};

    char_position_next  = char_position;
    radix_code_next     = radix_code;
    accumulator_next    = accumulator;
    overflowed_next     = overflowed;
    after_digit_next    = after_digit;
    malformed_next      = malformed;
    first_was_zero_next = first_was_zero;

    if (took_prefix) begin
      radix_code_next  = prefix_code;
      accumulator_next = '0;
      after_digit_next = 1'b0;
    end else if (s_tdata == ilp_pkg::CH_SEP) begin
      if (!after_digit) begin
        malformed_next = 1'b1;
      end
      after_digit_next = 1'b0;
    end else if (digit >= ilp_pkg::radix_base(radix_code)) begin
      malformed_next   = 1'b1;
      after_digit_next = 1'b0;
    end else begin
      if (!overflowed) begin
        if (sum[VW+3:VW] != 4'd0) begin
          overflowed_next = 1'b1;
        end else begin
          accumulator_next = sum[VW-1:0];
        end
      end
      if (char_position == 2'd0 && s_tdata == ilp_pkg::CH_ZERO) begin
        first_was_zero_next = 1'b1;
      end
      after_digit_next = 1'b1;
    end

    if (char_position != 2'd2) begin
      char_position_next = char_position + 2'd1;
    end

    good = !malformed_next && !overflowed_next && after_digit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= 2'd0;
      radix_code     <= ilp_pkg::RADIX_DEC;
      accumulator    <= '0;
      overflowed     <= 1'b0;
      after_digit    <= 1'b0;
      malformed      <= 1'b0;
      first_was_zero <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (s_fire && s_tlast) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s_fire) begin
        if (s_tlast) begin
          char_position  <= 2'd0;
          radix_code     <= ilp_pkg::RADIX_DEC;
          accumulator    <= '0;
          overflowed     <= 1'b0;
          after_digit    <= 1'b0;
          malformed      <= 1'b0;
          first_was_zero <= 1'b0;
        end else begin
          char_position  <= char_position_next;
          radix_code     <= radix_code_next;
          accumulator    <= accumulator_next;
          overflowed     <= overflowed_next;
          after_digit    <= after_digit_next;
          malformed      <= malformed_next;
          first_was_zero <= first_was_zero_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_tlast) begin
      m_tuser <= good;
      m_tdata <= good ? {1'b0, accumulator_next} : 32'd0;
    end
  end

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tlast |=> m_tvalid)
    else $error("no result word after the last character");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tlast |=> char_position == 2'd0 && !malformed && !overflowed &&
                          accumulator == '0)
    else $error("parse state not cleared after a literal");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
    else $error("failed literal gives a nonzero value");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    char_position != 2'd3)
    else $error("character position out of range");

  a_no_prefix_late: assert property (@(posedge clk) disable iff (rst)
    s_fire && !s_tlast && char_position == 2'd2 |=> $stable(radix_code))
    else $error("radix changed after the second character");

endmodule
